// ===== design/att_pkg.sv =====
// Package for the allocation tracking table.
// Operation, result kind and status codes, controller command types.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package att_pkg;

	typedef enum logic [1:0] {
		OP_TAG    = 2'd0,
		OP_RECORD = 2'd1,
		OP_CLEAR  = 2'd2,
		OP_DUMP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		KIND_ACK     = 2'd0,
		KIND_ENTRY   = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_MISS    = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	// controller -> datapath
	typedef struct packed {
		logic    load;      // latch input word, reset scan index
		logic    rd;        // issue read of slot at scan index
		logic    step;      // advance scan index
		logic    tag;       // apply tag operation
		logic    wr_rec;    // write record at scan index
		logic    wr_clr;    // free slot at scan index
		logic    drop;      // record on full table
		logic    dump_emit; // emit read slot as dump entry
		logic    dump_end;  // emit summary, reset counters
		logic    ack;       // emit acknowledge
		status_t ack_status;
	} att_cmd_t;

	// datapath -> controller
	typedef struct packed {
		op_t  op;
		logic addr_zero;
		logic size_zero;
		logic slot_empty;  // read slot is invalid or has zero address
		logic slot_match;  // read slot address equals input address
		logic scan_last;   // read slot is the last slot
	} att_sts_t;

endpackage
`default_nettype wire

// ===== design/att_datapath.sv =====
// Datapath for the allocation tracking table: slot memory, scan index,
// counters, pending tag, result registers. Uses att_pkg.
`timescale 1ns / 1ps
`default_nettype none
module att_datapath import att_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [1:0]  operation,
	input  wire logic [31:0] address,
	input  wire logic [31:0] alloc_size,
	input  wire logic [31:0] source_tag,
	input  wire logic [31:0] source_line,
	input  wire att_cmd_t    cmd,
	output att_sts_t         sts,
	output logic             res_valid,
	output logic [1:0]       kind,
	output logic [1:0]       status,
	output logic [31:0]      entry_address,
	output logic [31:0]      entry_size,
	output logic [31:0]      entry_seq,
	output logic [31:0]      entry_tag,
	output logic [31:0]      entry_line,
	output logic [5:0]       live_count,
	output logic [31:0]      seq_number,
	output logic [31:0]      total_bytes,
	output logic             last
);
	localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// slot memory: address/size/seq and tag/line in separate arrays;
	// slots carry valid bits so dump clears them all by resetting vld_q
	logic [31:0] mem_addr_q [TABLE_DEPTH];
	logic [31:0] mem_size_q [TABLE_DEPTH];
	logic [31:0] mem_seq_q  [TABLE_DEPTH];
	logic [31:0] mem_tag_q  [TABLE_DEPTH];
	logic [31:0] mem_line_q [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] vld_q;

	logic [1:0]  op_q;
	logic [31:0] addr_q, size_q, tag_q, line_q;
	logic [IW-1:0] idx_q, rd_idx_q;
	logic        rd_vld_q;
	logic [31:0] rd_addr_q, rd_size_q, rd_seq_q, rd_tag_q, rd_line_q;
	logic [31:0] seq_q, ptag_q, pline_q, total_q;
	logic [5:0]  count_q, found_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= operation;
			addr_q <= address;
			size_q <= alloc_size;
			tag_q  <= source_tag;
			line_q <= source_line;
		end
		if (cmd.rd) begin
			rd_addr_q <= mem_addr_q[idx_q];
			rd_size_q <= mem_size_q[idx_q];
			rd_seq_q  <= mem_seq_q[idx_q];
			rd_tag_q  <= mem_tag_q[idx_q];
			rd_line_q <= mem_line_q[idx_q];
			rd_idx_q  <= idx_q;
		end
		if (cmd.wr_rec) begin
			mem_addr_q[rd_idx_q] <= addr_q;
			mem_size_q[rd_idx_q] <= size_q;
			mem_seq_q[rd_idx_q]  <= seq_q + 32'd1;
			mem_tag_q[rd_idx_q]  <= ptag_q;
			mem_line_q[rd_idx_q] <= pline_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
			idx_q    <= '0;
			seq_q    <= '0;
			count_q  <= '0;
			ptag_q   <= '0;
			pline_q  <= '0;
			total_q  <= '0;
			found_q  <= '0;
		end else begin
			if (cmd.rd)
				rd_vld_q <= vld_q[idx_q];
			if (cmd.load) begin
				idx_q   <= '0;
				total_q <= '0;
				found_q <= '0;
			end else if (cmd.step) begin
				idx_q <= idx_q + IW'(1);
			end
			if (cmd.tag && ptag_q == 32'd0) begin
				ptag_q  <= tag_q;
				pline_q <= line_q;
			end
			if (cmd.wr_rec) begin
				vld_q[rd_idx_q] <= 1'b1;
				seq_q   <= seq_q + 32'd1;
				count_q <= count_q + 6'd1;
			end
			if (cmd.wr_rec || cmd.drop) begin
				ptag_q  <= '0;
				pline_q <= '0;
			end
			if (cmd.wr_clr) begin
				vld_q[rd_idx_q] <= 1'b0;
				count_q <= count_q - 6'd1;
			end
			if (cmd.dump_emit) begin
				total_q <= total_q + rd_size_q;
				found_q <= found_q + 6'd1;
			end
			if (cmd.dump_end) begin
				vld_q   <= '0;
				seq_q   <= '0;
				count_q <= '0;
			end
		end
	end

	always_comb begin
		sts.op         = op_t'(op_q);
		sts.addr_zero  = (addr_q == 32'd0);
		sts.size_zero  = (size_q == 32'd0);
		sts.slot_empty = !rd_vld_q || rd_addr_q == 32'd0;
		sts.slot_match = !sts.slot_empty && rd_addr_q == addr_q;
		sts.scan_last  = (rd_idx_q == IW'(TABLE_DEPTH - 1));
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
		end else begin
			res_valid <= cmd.ack || cmd.dump_emit || cmd.dump_end;
		end
	end

	always_ff @(posedge clk) begin
		kind          <= KIND_ACK;
		status        <= cmd.ack_status;
		entry_address <= '0;
		entry_size    <= '0;
		entry_seq     <= '0;
		entry_tag     <= '0;
		entry_line    <= '0;
		total_bytes   <= '0;
		last          <= 1'b1;
		live_count    <= count_q;
		seq_number    <= seq_q;
		if (cmd.ack) begin
			if (cmd.wr_rec) begin
				live_count <= count_q + 6'd1;
				seq_number <= seq_q + 32'd1;
			end else if (cmd.wr_clr) begin
				live_count <= count_q - 6'd1;
			end
		end else if (cmd.dump_emit) begin
			kind          <= KIND_ENTRY;
			status        <= ST_OK;
			entry_address <= rd_addr_q;
			entry_size    <= rd_size_q;
			entry_seq     <= rd_seq_q;
			entry_tag     <= rd_tag_q;
			entry_line    <= rd_line_q;
			last          <= 1'b0;
		end else if (cmd.dump_end) begin
			kind        <= KIND_SUMMARY;
			status      <= ST_OK;
			live_count  <= found_q;
			seq_number  <= '0;
			total_bytes <= total_q;
		end
	end
endmodule
`default_nettype wire

// ===== design/att_ctrl.sv =====
// Controller for the allocation tracking table: sequences the slot scan
// for each command word. Uses att_pkg.
`timescale 1ns / 1ps
`default_nettype none
module att_ctrl import att_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     start,
	output logic          busy,
	input  wire att_sts_t sts,
	output att_cmd_t      cmd
);
	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_DEC    = 5'b00010,
		S_READ   = 5'b00100,
		S_CHECK  = 5'b01000,
		S_SUM    = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= S_IDLE;
		else
			state_q <= state_d;
	end

	assign busy = (state_q != S_IDLE);

	always_comb begin
		cmd = '0;
		cmd.ack_status = ST_OK;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d = S_DEC;
				end
			end
			S_DEC: begin
				unique case (sts.op)
					OP_TAG: begin
						cmd.tag = 1'b1;
						cmd.ack = 1'b1;
						state_d = S_IDLE;
					end
					OP_RECORD: begin
						if (sts.addr_zero || sts.size_zero) begin
							cmd.ack = 1'b1;
							cmd.ack_status = ST_IGNORED;
							state_d = S_IDLE;
						end else begin
							cmd.rd = 1'b1;
							cmd.step = 1'b1;
							state_d = S_CHECK;
						end
					end
					OP_CLEAR: begin
						if (sts.addr_zero) begin
							cmd.ack = 1'b1;
							cmd.ack_status = ST_IGNORED;
							state_d = S_IDLE;
						end else begin
							cmd.rd = 1'b1;
							cmd.step = 1'b1;
							state_d = S_CHECK;
						end
					end
					OP_DUMP: begin
						cmd.rd = 1'b1;
						cmd.step = 1'b1;
						state_d = S_CHECK;
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_READ: begin
				cmd.rd = 1'b1;
				cmd.step = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				state_d = S_READ;
				case (sts.op)
					OP_RECORD: begin
						if (sts.slot_empty) begin
							cmd.wr_rec = 1'b1;
							cmd.ack = 1'b1;
							state_d = S_IDLE;
						end else if (sts.scan_last) begin
							cmd.drop = 1'b1;
							cmd.ack = 1'b1;
							cmd.ack_status = ST_FULL;
							state_d = S_IDLE;
						end
					end
					OP_CLEAR: begin
						if (sts.slot_match) begin
							cmd.wr_clr = 1'b1;
							cmd.ack = 1'b1;
							state_d = S_IDLE;
						end else if (sts.scan_last) begin
							cmd.ack = 1'b1;
							cmd.ack_status = ST_MISS;
							state_d = S_IDLE;
						end
					end
					default: begin
						if (!sts.slot_empty)
							cmd.dump_emit = 1'b1;
						if (sts.scan_last)
							state_d = S_SUM;
					end
				endcase
			end
			// dump summary goes out in the state after the check of the last slot
			S_SUM: begin
				cmd.dump_end = 1'b1;
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end
endmodule
`default_nettype wire

// ===== design/allocation_tracking_table.sv =====
// Allocation tracking table, top level: controller plus datapath.
// Depends on att_pkg, att_ctrl, att_datapath.
//
// A word is taken when start is high and busy is low. Each result is on the
// ports for one cycle, marked by res_valid, and cannot be stalled. Tag and
// ignored operations are acknowledged from the decode state; record and clear
// read one slot at a time and stop at the first free (record) or matching
// (clear) slot or at the last slot, and dump always scans every slot and
// then adds a summary; busy stays high until the word is done. Dump sends one
// entry per live slot, then a summary once the scan ends.
`timescale 1ns / 1ps
`default_nettype none
module allocation_tracking_table import att_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  operation,
	input  wire logic [31:0] address,
	input  wire logic [31:0] alloc_size,
	input  wire logic [31:0] source_tag,
	input  wire logic [31:0] source_line,
	output logic             res_valid,
	output logic [1:0]       kind,
	output logic [1:0]       status,
	output logic [31:0]      entry_address,
	output logic [31:0]      entry_size,
	output logic [31:0]      entry_seq,
	output logic [31:0]      entry_tag,
	output logic [31:0]      entry_line,
	output logic [5:0]       live_count,
	output logic [31:0]      seq_number,
	output logic [31:0]      total_bytes,
	output logic             last
);
	att_cmd_t cmd;
	att_sts_t sts;

	att_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	att_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.operation     (operation),
		.address       (address),
		.alloc_size    (alloc_size),
		.source_tag    (source_tag),
		.source_line   (source_line),
		.cmd           (cmd),
		.sts           (sts),
		.res_valid     (res_valid),
		.kind          (kind),
		.status        (status),
		.entry_address (entry_address),
		.entry_size    (entry_size),
		.entry_seq     (entry_seq),
		.entry_tag     (entry_tag),
		.entry_line    (entry_line),
		.live_count    (live_count),
		.seq_number    (seq_number),
		.total_bytes   (total_bytes),
		.last          (last)
	);
endmodule
`default_nettype wire

// ===== dv/att_checker.sv =====
// Checker for the allocation tracking table: predicts results from accepted words.
// Watches the command and result ports of the block; depends on att_pkg.
`timescale 1ns / 1ps
module att_checker import att_pkg::*; #(
	parameter int TABLE_DEPTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  operation,
	input  logic [31:0] address,
	input  logic [31:0] alloc_size,
	input  logic [31:0] source_tag,
	input  logic [31:0] source_line,
	input  logic        res_valid,
	input  logic [1:0]  kind,
	input  logic [1:0]  status,
	input  logic [31:0] entry_address,
	input  logic [31:0] entry_size,
	input  logic [31:0] entry_seq,
	input  logic [31:0] entry_tag,
	input  logic [31:0] entry_line,
	input  logic [5:0]  live_count,
	input  logic [31:0] seq_number,
	input  logic [31:0] total_bytes,
	input  logic        last,
	output int          fail_count,
	output int          pending,
	output int          seen_entries,
	output int          seen_full
);
	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [31:0] addr;
		logic [31:0] size;
		logic [31:0] seq;
		logic [31:0] tag;
		logic [31:0] line;
		logic [5:0]  count;
		logic [31:0] seqn;
		logic [31:0] total;
		logic        last;
	} alloc_word_t;

	alloc_word_t expected_words[$];
	logic [31:0] tbl_addr[TABLE_DEPTH];
	logic [31:0] tbl_size[TABLE_DEPTH];
	logic [31:0] tbl_seq[TABLE_DEPTH];
	logic [31:0] tbl_tag[TABLE_DEPTH];
	logic [31:0] tbl_line[TABLE_DEPTH];
	logic [31:0] seq_ctr;
	logic [5:0]  live;
	logic [31:0] held_tag, held_line;

	function automatic alloc_word_t ack_word(status_t st);
		alloc_word_t w;
		w = '0;
		w.kind = KIND_ACK;
		w.status = st;
		w.count = live;
		w.seqn = seq_ctr;
		w.last = 1'b1;
		return w;
	endfunction

	task automatic predict_alloc(op_t op, logic [31:0] a, logic [31:0] sz,
			logic [31:0] tg, logic [31:0] ln);
		alloc_word_t w;
		logic [31:0] sum;
		logic [5:0] found;
		bit done;
		done = 0;
		sum = '0;
		found = '0;
		case (op)
			OP_TAG: begin
				if (held_tag == 0) begin
					held_tag = tg;
					held_line = ln;
				end
				expected_words.push_back(ack_word(ST_OK));
			end
			OP_RECORD: begin
				if (a == 0 || sz == 0) begin
					expected_words.push_back(ack_word(ST_IGNORED));
				end else begin
					for (int i = 0; i < TABLE_DEPTH && !done; i++) begin
						if (tbl_addr[i] == 0) begin
							seq_ctr++;
							tbl_addr[i] = a;
							tbl_size[i] = sz;
							tbl_seq[i] = seq_ctr;
							tbl_tag[i] = held_tag;
							tbl_line[i] = held_line;
							live++;
							done = 1;
						end
					end
					held_tag = 0;
					held_line = 0;
					expected_words.push_back(ack_word(done ? ST_OK : ST_FULL));
				end
			end
			OP_CLEAR: begin
				if (a == 0) begin
					expected_words.push_back(ack_word(ST_IGNORED));
				end else begin
					for (int i = 0; i < TABLE_DEPTH && !done; i++) begin
						if (tbl_addr[i] == a) begin
							tbl_addr[i] = 0;
							tbl_size[i] = 0;
							tbl_seq[i] = 0;
							live--;
							done = 1;
						end
					end
					expected_words.push_back(ack_word(done ? ST_OK : ST_MISS));
				end
			end
			default: begin
				for (int i = 0; i < TABLE_DEPTH; i++) begin
					if (tbl_addr[i] != 0) begin
						w = '0;
						w.kind = KIND_ENTRY;
						w.status = ST_OK;
						w.addr = tbl_addr[i];
						w.size = tbl_size[i];
						w.seq = tbl_seq[i];
						w.tag = tbl_tag[i];
						w.line = tbl_line[i];
						w.count = live;
						w.seqn = seq_ctr;
						expected_words.push_back(w);
						found++;
						sum += tbl_size[i];
					end
					tbl_addr[i] = 0;
					tbl_size[i] = 0;
					tbl_seq[i] = 0;
					tbl_tag[i] = 0;
					tbl_line[i] = 0;
				end
				seq_ctr = 0;
				live = 0;
				w = '0;
				w.kind = KIND_SUMMARY;
				w.status = ST_OK;
				w.count = found;
				w.total = sum;
				w.last = 1'b1;
				expected_words.push_back(w);
			end
		endcase
	endtask

	task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (exp_v !== act_v) begin
			$error("%s: expected %0h, got %0h", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	initial begin
		fail_count = 0;
		seen_entries = 0;
		seen_full = 0;
		seq_ctr = 0;
		live = 0;
		held_tag = 0;
		held_line = 0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			tbl_addr[i] = 0;
			tbl_size[i] = 0;
			tbl_seq[i] = 0;
			tbl_tag[i] = 0;
			tbl_line[i] = 0;
		end
	end

	assign pending = expected_words.size();

	always @(posedge clk) begin
		alloc_word_t e;
		if (arst_n) begin
			if (res_valid) begin
				if (expected_words.size() == 0) begin
					$error("result word with none expected");
					fail_count++;
				end else begin
					e = expected_words.pop_front();
					if (e.kind == KIND_ENTRY) seen_entries++;
					if (e.status == ST_FULL) seen_full++;
					compare_field("kind", 32'(e.kind), 32'(kind));
					compare_field("status", 32'(e.status), 32'(status));
					compare_field("entry_address", e.addr, entry_address);
					compare_field("entry_size", e.size, entry_size);
					compare_field("entry_seq", e.seq, entry_seq);
					compare_field("entry_tag", e.tag, entry_tag);
					compare_field("entry_line", e.line, entry_line);
					compare_field("live_count", 32'(e.count), 32'(live_count));
					compare_field("seq_number", e.seqn, seq_number);
					compare_field("total_bytes", e.total, total_bytes);
					compare_field("last", 32'(e.last), 32'(last));
				end
			end
			if (start && !busy)
				predict_alloc(op_t'(operation), address, alloc_size, source_tag, source_line);
		end
	end
endmodule

// ===== dv/tb_top.sv =====
// Testbench top for the allocation tracking table: clock, reset, stimulus, verdict.
// Depends on att_pkg, allocation_tracking_table and att_checker.
`timescale 1ns / 1ps
module tb_top;
	import att_pkg::*;

	localparam int DEPTH = 32;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 0, arst_n = 0, start = 0;
	logic [1:0] operation = '0;
	logic [31:0] address = '0, alloc_size = '0, source_tag = '0, source_line = '0;
	logic busy, res_valid, last;
	logic [1:0] kind, status;
	logic [31:0] entry_address, entry_size, entry_seq, entry_tag, entry_line;
	logic [31:0] seq_number, total_bytes;
	logic [5:0] live_count;
	int fail_count, pending, seen_entries, seen_full;
	int cycles = 0, words_sent = 0, idle_pct = 0;
	logic [31:0] addr_pool[16];

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	allocation_tracking_table #(.TABLE_DEPTH(DEPTH)) dut (.*);
	att_checker #(.TABLE_DEPTH(DEPTH)) chk (.*);

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout at cycle %0d", cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// drive one word; holds start until accepted, drops it only while idle
	task automatic send_word(op_t op, logic [31:0] a, logic [31:0] sz,
			logic [31:0] tg, logic [31:0] ln);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		operation <= op;
		address <= a;
		alloc_size <= sz;
		source_tag <= tg;
		source_line <= ln;
		@(posedge clk);
		while (busy) @(posedge clk);
		words_sent++;
	endtask

	task automatic random_word();
		int r;
		logic [31:0] a;
		r = $urandom_range(99);
		a = ($urandom_range(3) == 0) ? $urandom : addr_pool[$urandom_range(15)];
		if (r < 20)
			send_word(OP_TAG, $urandom, $urandom, ($urandom_range(9) == 0) ? 0 : $urandom,
				$urandom);
		else if (r < 62)
			send_word(OP_RECORD, ($urandom_range(19) == 0) ? 0 : a,
				($urandom_range(19) == 0) ? 0 : $urandom, $urandom, $urandom);
		else if (r < 94)
			send_word(OP_CLEAR, ($urandom_range(19) == 0) ? 0 : a, $urandom,
				$urandom, $urandom);
		else
			send_word(OP_DUMP, $urandom, $urandom, $urandom, $urandom);
	endtask

	initial begin
		for (int i = 0; i < 16; i++) addr_pool[i] = $urandom | 32'h1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: extremes, every operation, null, miss, full, wrap of total
		send_word(OP_DUMP, 0, 0, 0, 0);
		send_word(OP_TAG, 0, 0, 0, 32'hFFFF_FFFF);
		send_word(OP_TAG, 0, 0, 32'hFFFF_FFFF, 32'h1234);
		send_word(OP_RECORD, 0, 5, 0, 0);
		send_word(OP_RECORD, 7, 0, 0, 0);
		send_word(OP_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0);
		send_word(OP_TAG, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(OP_TAG, 0, 0, 32'h5, 32'h6);
		send_word(OP_RECORD, 32'h1, 32'h2, 0, 0);
		send_word(OP_CLEAR, 0, 0, 0, 0);
		send_word(OP_CLEAR, 32'h99, 0, 0, 0);
		send_word(OP_CLEAR, 32'h1, 0, 0, 0);
		for (int i = 0; i < DEPTH + 1; i++)
			send_word(OP_RECORD, 32'h100 + i, 32'h8000_0000 + i, 0, 0);
		send_word(OP_CLEAR, 32'h105, 0, 0, 0);
		send_word(OP_RECORD, 32'hAAAA_5555, 32'h5555_AAAA, 0, 0);
		send_word(OP_DUMP, 0, 0, 0, 0);
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 65 : (ph == 3) ? 28 : 0;
			for (int n = 0; n < 70; n++) begin
				if (n == 10) begin
					// long fill run to reach a full table
					for (int k = 0; k < DEPTH + 2; k++)
						send_word(OP_RECORD, $urandom | 32'h1, $urandom | 32'h1, 0, 0);
				end
				random_word();
			end
		end
		send_word(OP_DUMP, 0, 0, 0, 0);
		start <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (2 * DEPTH + 10) @(posedge clk);
		$display("sent %0d words; %0d dumped entries, %0d full-table drops checked",
			words_sent, seen_entries, seen_full);
		if (fail_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
